@@ rtl/hthq_pkg.sv @@
//------------------------------------------------------------------------------
// hthq_pkg
// Shared widths, command and register codes for the terrain height query.
//------------------------------------------------------------------------------
`default_nettype none

package hthq_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int POS_W         = 16;
  localparam int CELL_W        = POS_W - FRAC_BITS;
  localparam int MAX_GRID_SIDE = 256;
  localparam int SIDE_W        = 9;
  localparam int STORE_DEPTH   = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int ADDR_W        = 16;
  localparam int HEIGHT_W      = 8;
  localparam int VALUE_W       = 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH = 1'd1;

endpackage

`default_nettype wire

@@ rtl/hthq_in_if.sv @@
//------------------------------------------------------------------------------
// hthq_in_if
// Input channel: load or query word with valid/ready handshake.
//------------------------------------------------------------------------------
`default_nettype none

interface hthq_in_if;
  import hthq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ADDR_W-1:0]          sample_addr;
  logic [HEIGHT_W-1:0]        sample_height;
  logic [POS_W-1:0]           pos_x;
  logic [POS_W-1:0]           pos_z;

  modport source (
    output valid, cmd, sample_addr, sample_height, pos_x, pos_z,
    input  ready
  );

  modport sink (
    input  valid, cmd, sample_addr, sample_height, pos_x, pos_z,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/hthq_out_if.sv @@
//------------------------------------------------------------------------------
// hthq_out_if
// Result channel: interpolated height word with valid/ready handshake.
//------------------------------------------------------------------------------
`default_nettype none

interface hthq_out_if;
  import hthq_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] height_value;
  logic               out_of_range;
  logic               was_query;

  modport source (
    output valid, height_value, out_of_range, was_query,
    input  ready
  );

  modport sink (
    input  valid, height_value, out_of_range, was_query,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/hthq_ram.sv @@
//------------------------------------------------------------------------------
// hthq_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module hthq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/heightmap_terrain_height_query.sv @@
//------------------------------------------------------------------------------
// heightmap_terrain_height_query
// Loads an 8-bit height grid and answers triangle-plane height queries.
//------------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per handshake: cmd 0 writes sample_height at
//   sample_addr, cmd 1 queries the height at Q8.8 position (pos_x, pos_z).
//   out_ch returns one word per input word, in order: a load acknowledge
//   (all zero) or the interpolated height with 8 fraction bits, with
//   out_of_range set when the cell falls outside the configured grid.
//   cfg_we/cfg_index/cfg_wdata write grid_width (0) and grid_depth (1);
//   write them only while the pipeline is empty.
// Timing:
//   One word per cycle sustained while out_ch accepts results. From the
//   accepting edge the input register loads, then the height store read
//   (four copies, one per cell corner), the multiply register and the sum
//   with output register follow in that order.
// Reset:
//   rst_n clears the pipeline valid bits and sets both grid sizes to 256.
//   The height store is not cleared; read only samples that were loaded.
// Stall:
//   When out_ch is not ready and a result is held, the whole pipeline and
//   in_ch.ready hold; nothing is dropped or repeated.
//------------------------------------------------------------------------------
`default_nettype none

module heightmap_terrain_height_query (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  hthq_in_if.sink                                in_ch,
  hthq_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [hthq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hthq_pkg::SIDE_W-1:0]       cfg_wdata
);
  import hthq_pkg::*;

  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_GRID_SIDE);
  localparam logic [SIDE_W-1:0] ONE_UNIT = SIDE_W'(1 << FRAC_BITS);
  localparam int SUM_W  = 21;
  localparam int PROD_W = 19;

  // configuration
  logic [SIDE_W-1:0] grid_width_r;
  logic [SIDE_W-1:0] grid_depth_r;
  logic [SIDE_W-1:0] eff_w;
  logic [SIDE_W-1:0] eff_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= SIDE_MAX;
      grid_depth_r <= SIDE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH: grid_width_r <= cfg_wdata;
        CFG_GRID_DEPTH: grid_depth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_w = (grid_width_r > SIDE_MAX) ? SIDE_MAX : grid_width_r;
  assign eff_d = (grid_depth_r > SIDE_MAX) ? SIDE_MAX : grid_depth_r;

  // global advance
  logic out_valid_r;
  logic adv;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 0: split position, range check, row base
  logic [CELL_W-1:0]    in_x0;
  logic [CELL_W-1:0]    in_z0;
  logic [FRAC_BITS-1:0] in_fx;
  logic [FRAC_BITS-1:0] in_fz;
  logic                 in_oor;
  logic [CELL_W+SIDE_W-1:0] in_base;

  assign in_x0   = in_ch.pos_x[POS_W-1:FRAC_BITS];
  assign in_z0   = in_ch.pos_z[POS_W-1:FRAC_BITS];
  assign in_fx   = in_ch.pos_x[FRAC_BITS-1:0];
  assign in_fz   = in_ch.pos_z[FRAC_BITS-1:0];
  assign in_oor  = ((SIDE_W'(in_x0) + SIDE_W'(1)) >= eff_w) ||
                   ((SIDE_W'(in_z0) + SIDE_W'(1)) >= eff_d);
  assign in_base = (CELL_W+SIDE_W)'(in_z0) * (CELL_W+SIDE_W)'(eff_w);

  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic [HEIGHT_W-1:0]  s1_height_r;
  logic [CELL_W-1:0]    s1_x0_r;
  logic [FRAC_BITS-1:0] s1_fx_r;
  logic [SIDE_W-1:0]    s1_wz_r;
  logic                 s1_oor_r;
  logic [ADDR_W-1:0]    s1_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_addr_r   <= in_ch.sample_addr;
      s1_height_r <= in_ch.sample_height;
      s1_x0_r     <= in_x0;
      s1_fx_r     <= in_fx;
      s1_wz_r     <= ONE_UNIT - SIDE_W'(in_fz);
      s1_oor_r    <= in_oor;
      s1_base_r   <= in_base[ADDR_W-1:0];
    end
  end

  // stage 1: corner addresses, store write or read
  logic [ADDR_W-1:0] a0;
  logic [ADDR_W-1:0] a1;
  logic [ADDR_W-1:0] a2;
  logic [ADDR_W-1:0] a3;
  logic              st_we;
  logic [HEIGHT_W-1:0] h0;
  logic [HEIGHT_W-1:0] h1;
  logic [HEIGHT_W-1:0] h2;
  logic [HEIGHT_W-1:0] h3;

  assign a3    = s1_base_r + ADDR_W'(s1_x0_r);
  assign a2    = a3 + ADDR_W'(1);
  assign a0    = a3 + ADDR_W'(eff_w);
  assign a1    = a0 + ADDR_W'(1);
  assign st_we = adv && s1_valid_r && (s1_cmd_r == CMD_LOAD);

  hthq_ram #(.WIDTH(HEIGHT_W), .DEPTH(STORE_DEPTH)) u_ram_c0 (
    .clk(clk), .we(st_we), .waddr(s1_addr_r), .wdata(s1_height_r),
    .re(adv), .raddr(a0), .rdata(h0)
  );

  hthq_ram #(.WIDTH(HEIGHT_W), .DEPTH(STORE_DEPTH)) u_ram_c1 (
    .clk(clk), .we(st_we), .waddr(s1_addr_r), .wdata(s1_height_r),
    .re(adv), .raddr(a1), .rdata(h1)
  );

  hthq_ram #(.WIDTH(HEIGHT_W), .DEPTH(STORE_DEPTH)) u_ram_c2 (
    .clk(clk), .we(st_we), .waddr(s1_addr_r), .wdata(s1_height_r),
    .re(adv), .raddr(a2), .rdata(h2)
  );

  hthq_ram #(.WIDTH(HEIGHT_W), .DEPTH(STORE_DEPTH)) u_ram_c3 (
    .clk(clk), .we(st_we), .waddr(s1_addr_r), .wdata(s1_height_r),
    .re(adv), .raddr(a3), .rdata(h3)
  );

  logic                 s2_valid_r;
  logic                 s2_query_r;
  logic                 s2_oor_r;
  logic [FRAC_BITS-1:0] s2_fx_r;
  logic [SIDE_W-1:0]    s2_wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_query_r <= (s1_cmd_r == CMD_QUERY);
      s2_oor_r   <= s1_oor_r;
      s2_fx_r    <= s1_fx_r;
      s2_wz_r    <= s1_wz_r;
    end
  end

  // stage 2: triangle pick and edge products
  logic                        upper;
  logic signed [HEIGHT_W:0]    d1;
  logic signed [HEIGHT_W:0]    d2;
  logic        [SIDE_W-1:0]    m1;
  logic        [SIDE_W-1:0]    m2;
  logic signed [PROD_W-1:0]    p1;
  logic signed [PROD_W-1:0]    p2;

  always_comb begin
    upper = SIDE_W'(s2_fx_r) > s2_wz_r;
    if (upper) begin
      d1 = $signed({1'b0, h1}) - $signed({1'b0, h0});
      d2 = $signed({1'b0, h2}) - $signed({1'b0, h1});
      m1 = SIDE_W'(s2_fx_r);
      m2 = s2_wz_r;
    end else begin
      d1 = $signed({1'b0, h3}) - $signed({1'b0, h0});
      d2 = $signed({1'b0, h2}) - $signed({1'b0, h3});
      m1 = s2_wz_r;
      m2 = SIDE_W'(s2_fx_r);
    end
    p1 = PROD_W'(d1) * $signed({{(PROD_W-SIDE_W){1'b0}}, m1});
    p2 = PROD_W'(d2) * $signed({{(PROD_W-SIDE_W){1'b0}}, m2});
  end

  logic                     s3_valid_r;
  logic                     s3_query_r;
  logic                     s3_oor_r;
  logic [HEIGHT_W-1:0]      s3_h0_r;
  logic signed [PROD_W-1:0] s3_p1_r;
  logic signed [PROD_W-1:0] s3_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_query_r <= s2_query_r;
      s3_oor_r   <= s2_oor_r;
      s3_h0_r    <= h0;
      s3_p1_r    <= p1;
      s3_p2_r    <= p2;
    end
  end

  // stage 3: plane sum and clamp
  logic signed [SUM_W-1:0] y_sum;
  logic [VALUE_W-1:0]      y_clamp;
  logic [VALUE_W-1:0]      value_nxt;

  always_comb begin
    y_sum = $signed({{(SUM_W-HEIGHT_W-FRAC_BITS){1'b0}}, s3_h0_r, {FRAC_BITS{1'b0}}})
          + SUM_W'(s3_p1_r) + SUM_W'(s3_p2_r);
    if (y_sum < 0) begin
      y_clamp = '0;
    end else if (y_sum > $signed(SUM_W'({VALUE_W{1'b1}}))) begin
      y_clamp = '1;
    end else begin
      y_clamp = y_sum[VALUE_W-1:0];
    end
    value_nxt = (s3_query_r && !s3_oor_r) ? y_clamp : '0;
  end

  logic [VALUE_W-1:0] out_value_r;
  logic               out_oor_r;
  logic               out_query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= value_nxt;
      out_oor_r   <= s3_query_r && s3_oor_r;
      out_query_r <= s3_query_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.height_value = out_value_r;
  assign out_ch.out_of_range = out_oor_r;
  assign out_ch.was_query    = out_query_r;

endmodule

`default_nettype wire
